>>> design/led_blink_pattern_generator_macros.svh
// Assertion macros shared by the LED blink pattern generator RTL.
`ifndef LED_BLINK_PATTERN_GENERATOR_MACROS_SVH
`define LED_BLINK_PATTERN_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LBP_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LBP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/lbp_pkg.sv
// Types and constants shared by the LED blink pattern generator modules.
package lbp_pkg;

  // Kind of input word.
  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SET  = 1'b1
  } lbp_action_t;

  // LED modes; hold leaves the level alone.
  typedef enum logic [2:0] {
    MODE_HOLD   = 3'd0,
    MODE_OFF    = 3'd1,
    MODE_ON     = 3'd2,
    MODE_SHORT  = 3'd3,
    MODE_LONG   = 3'd4,
    MODE_TRIPLE = 3'd5
  } lbp_mode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SHORT_PERIOD = 2'd0,
    REG_LONG_PERIOD  = 2'd1,
    REG_BURST_GAP    = 2'd2,
    REG_BURST_LIMIT  = 2'd3
  } lbp_reg_t;

  localparam int unsigned TIMER_W    = 16;
  localparam int unsigned COUNT_W    = 8;
  localparam int unsigned INDEX_W    = 2;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned LEVELS_W   = 3;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [TIMER_W-1:0] SHORT_PERIOD_RST = 16'd100;
  localparam logic [TIMER_W-1:0] LONG_PERIOD_RST  = 16'd500;
  localparam logic [TIMER_W-1:0] BURST_GAP_RST    = 16'd800;
  localparam logic [COUNT_W-1:0] BURST_LIMIT_RST  = 8'd6;

  // Timer configuration as seen by the timer block.
  typedef struct packed {
    logic [TIMER_W-1:0] short_period;
    logic [TIMER_W-1:0] long_period;
    logic [TIMER_W-1:0] burst_gap;
    logic [COUNT_W-1:0] burst_count_limit;
  } lbp_cfg_t;

  // Timer events for the current tick.
  typedef struct packed {
    logic short_fire;
    logic long_fire;
    logic burst_fire;
  } lbp_fire_t;

endpackage

>>> design/lbp_timers.sv
// Shared short, long and triple-burst timers, advanced once per tick.
module lbp_timers
  import lbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      tick_en,
  input  lbp_cfg_t  cfg,
  output lbp_fire_t fire
);

  logic [TIMER_W-1:0] short_elapsed_r, short_elapsed_nxt;
  logic [TIMER_W-1:0] long_elapsed_r, long_elapsed_nxt;
  logic [TIMER_W-1:0] burst_elapsed_r, burst_elapsed_nxt;
  logic               in_burst_r, in_burst_nxt;
  logic [COUNT_W-1:0] burst_count_r, burst_count_nxt;

  logic [TIMER_W-1:0] short_inc, long_inc, burst_inc;

  // Saturating increments.
  assign short_inc = (short_elapsed_r == TIMER_MAX) ? TIMER_MAX : short_elapsed_r + 1'b1;
  assign long_inc  = (long_elapsed_r  == TIMER_MAX) ? TIMER_MAX : long_elapsed_r  + 1'b1;
  assign burst_inc = (burst_elapsed_r == TIMER_MAX) ? TIMER_MAX : burst_elapsed_r + 1'b1;

  // Short and long period timers.
  always_comb begin
    fire.short_fire   = (short_inc >= cfg.short_period);
    fire.long_fire    = (long_inc >= cfg.long_period);
    short_elapsed_nxt = fire.short_fire ? '0 : short_inc;
    long_elapsed_nxt  = fire.long_fire ? '0 : long_inc;
  end

  // Burst timer: wait the gap, then fire on the short period until the count passes the limit.
  always_comb begin
    fire.burst_fire   = 1'b0;
    burst_elapsed_nxt = burst_inc;
    in_burst_nxt      = in_burst_r;
    burst_count_nxt   = burst_count_r;
    if (in_burst_r) begin
      if (burst_inc >= cfg.short_period) begin
        fire.burst_fire   = 1'b1;
        burst_elapsed_nxt = '0;
        if (burst_count_r > cfg.burst_count_limit) begin
          in_burst_nxt    = 1'b0;
          burst_count_nxt = '0;
        end else if (burst_count_r != COUNT_MAX) begin
          burst_count_nxt = burst_count_r + 1'b1;
        end
      end
    end else if (burst_inc >= cfg.burst_gap) begin
      burst_elapsed_nxt = '0;
      in_burst_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_elapsed_r <= '0;
      long_elapsed_r  <= '0;
      burst_elapsed_r <= '0;
      in_burst_r      <= 1'b0;
      burst_count_r   <= '0;
    end else if (tick_en) begin
      short_elapsed_r <= short_elapsed_nxt;
      long_elapsed_r  <= long_elapsed_nxt;
      burst_elapsed_r <= burst_elapsed_nxt;
      in_burst_r      <= in_burst_nxt;
      burst_count_r   <= burst_count_nxt;
    end
  end

endmodule

>>> design/led_blink_pattern_generator.sv
// An accepted input word passes the input register, then the result register; out_tvalid rises
// when the word enters the result register, which it does once that register is free or drained.
// Throughput: one word per cycle while out_tready is high; timers and LEDs update as a word moves on.
// While a result waits, the input side takes one more word into an empty input register, then stalls.
// Reset (rst_n low, synchronous) restores default periods and clears timers, modes and levels.
// No clearing pass is needed after reset.
`include "led_blink_pattern_generator_macros.svh"

module led_blink_pattern_generator
  import lbp_pkg::*;
#(
  parameter int LED_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [1:0] led_index, [4:2] mode, [7:5] zero
  input  logic                  in_tuser,   // [0] action
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] led_levels, [3] accepted, [7:4] zero
  // Configuration writes.
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [TIMER_W-1:0]    cfg_wdata
);

  lbp_cfg_t cfg_r;

  logic               s1_valid_r;
  lbp_action_t        s1_action_r;
  logic [INDEX_W-1:0] s1_index_r;
  logic [MODE_W-1:0]  s1_mode_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  lbp_mode_t            led_mode_r [LED_COUNT];
  lbp_mode_t            led_mode_nxt [LED_COUNT];
  logic [LED_COUNT-1:0] led_level_r, led_level_nxt;

  logic      s1_adv, s1_fire, tick_en, mode_ok, set_ok;
  lbp_fire_t fire;
  logic [LEVELS_W-1:0] levels_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.short_period      <= SHORT_PERIOD_RST;
      cfg_r.long_period       <= LONG_PERIOD_RST;
      cfg_r.burst_gap         <= BURST_GAP_RST;
      cfg_r.burst_count_limit <= BURST_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (lbp_reg_t'(cfg_index))
        REG_SHORT_PERIOD: cfg_r.short_period      <= cfg_wdata;
        REG_LONG_PERIOD:  cfg_r.long_period       <= cfg_wdata;
        REG_BURST_GAP:    cfg_r.burst_gap         <= cfg_wdata;
        REG_BURST_LIMIT:  cfg_r.burst_count_limit <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input register moves on whenever the result register is free or drained.
  assign s1_adv    = !out_valid_r || out_tready;
  assign s1_fire   = s1_valid_r && s1_adv;
  assign in_tready = !s1_valid_r || s1_adv;
  assign tick_en   = s1_fire && (s1_action_r == ACT_TICK);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_action_r <= lbp_action_t'(in_tuser);
      s1_index_r  <= in_tdata[INDEX_W-1:0];
      s1_mode_r   <= in_tdata[INDEX_W +: MODE_W];
    end
  end

  lbp_timers u_timers (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_en),
    .cfg     (cfg_r),
    .fire    (fire)
  );

  // A set command is valid only for modes off through triple; hold and undefined codes are rejected.
  assign mode_ok = (s1_mode_r >= MODE_OFF) && (s1_mode_r <= MODE_TRIPLE);
  assign set_ok  = (s1_action_r == ACT_SET) && mode_ok;

  // Per-LED next state: a tick applies the mode, a valid set addresses one LED.
  for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
    always_comb begin
      led_mode_nxt[i]  = led_mode_r[i];
      led_level_nxt[i] = led_level_r[i];
      if (s1_action_r == ACT_TICK) begin
        unique case (led_mode_r[i])
          MODE_OFF: begin
            led_level_nxt[i] = 1'b0;
            led_mode_nxt[i]  = MODE_HOLD;
          end
          MODE_ON: begin
            led_level_nxt[i] = 1'b1;
            led_mode_nxt[i]  = MODE_HOLD;
          end
          MODE_SHORT:  led_level_nxt[i] = led_level_r[i] ^ fire.short_fire;
          MODE_LONG:   led_level_nxt[i] = led_level_r[i] ^ fire.long_fire;
          MODE_TRIPLE: led_level_nxt[i] = led_level_r[i] ^ fire.burst_fire;
          default: ;
        endcase
      end else if (set_ok && (int'(s1_index_r) == i)) begin
        led_level_nxt[i] = 1'b0;
        led_mode_nxt[i]  = lbp_mode_t'(s1_mode_r);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        led_mode_r[i]  <= MODE_HOLD;
        led_level_r[i] <= 1'b0;
      end else if (s1_fire) begin
        led_mode_r[i]  <= led_mode_nxt[i];
        led_level_r[i] <= led_level_nxt[i];
      end
    end
  end

  // Only the first three LEDs are reported; missing LEDs read low.
  for (genvar j = 0; j < LEVELS_W; j++) begin : g_lvl
    if (j < LED_COUNT) begin : g_on
      assign levels_nxt[j] = led_level_nxt[j];
    end else begin : g_off
      assign levels_nxt[j] = 1'b0;
    end
  end

  always_comb begin
    out_data_nxt                         = '0;
    out_data_nxt[LEVELS_W-1:0]           = levels_nxt;
    out_data_nxt[LEVELS_W]               = (s1_action_r == ACT_TICK) || mode_ok;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A command can only pull levels low, never raise one.
  `LBP_ASSERT_NOW(a_set_never_raises, s1_fire && (s1_action_r == ACT_SET),
                  (led_level_nxt & ~led_level_r) == '0, "set command raised an LED level")
  // A tick is always reported as accepted.
  `LBP_ASSERT_NOW(a_tick_accepted, s1_fire && (s1_action_r == ACT_TICK),
                  out_data_nxt[LEVELS_W], "tick word reported as rejected")
  // An empty result register never blocks the input side.
  `LBP_ASSERT_NOW(a_ready_when_empty, !out_valid_r, in_tready,
                  "input stalled with result register empty")
  // A word waiting in the input register keeps its contents until it moves on.
  `LBP_ASSERT_NEXT(a_s1_holds, s1_valid_r && !s1_adv,
                   s1_valid_r && $stable(s1_index_r) && $stable(s1_mode_r),
                   "input register changed while stalled")

endmodule

>>> tb/led_blink_pattern_generator_tb.sv
// Self-checking testbench for the LED blink pattern generator: directed, random and stall tests.
module led_blink_pattern_generator_tb
  import lbp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LED_COUNT      = 3;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ERROR_PRINTS   = 50;

  // One expected result word, in the order of its fields.
  typedef struct packed {
    logic [LEVELS_W-1:0] levels;
    logic                accepted;
  } led_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [1:0] led_index, [4:2] mode, [7:5] zero
  logic                  in_tuser;   // [0] action
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [2:0] led_levels, [3] accepted, [7:4] zero
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [TIMER_W-1:0]    cfg_wdata;

  // Shadow copy of the block's configuration and state.
  logic [TIMER_W-1:0]  short_period, long_period, burst_gap;
  logic [COUNT_W-1:0]  burst_limit;
  logic [TIMER_W-1:0]  short_el, long_el, burst_el;
  logic                in_burst;
  logic [COUNT_W-1:0]  burst_cnt;
  lbp_mode_t           led_mode [LED_COUNT];
  logic [LEVELS_W-1:0] led_lvl;

  led_result_t pending_levels[$];
  int          error_count;
  int          words_checked;
  bit          idle_en;
  int          stall_left;
  int          hold_off_left;

  led_blink_pattern_generator #(.LED_COUNT(LED_COUNT)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Prints one mismatch line and counts it; printing stops after ERROR_PRINTS lines.
  task automatic report_mismatch(input string msg);
    if (error_count < ERROR_PRINTS) begin
      $display("MISMATCH at result word %0d: %s", words_checked, msg);
    end
    error_count++;
  endtask

  function automatic logic [TIMER_W-1:0] sat_inc(input logic [TIMER_W-1:0] v);
    return (v == TIMER_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void reset_model();
    short_period = SHORT_PERIOD_RST;
    long_period  = LONG_PERIOD_RST;
    burst_gap    = BURST_GAP_RST;
    burst_limit  = BURST_LIMIT_RST;
    short_el     = '0;
    long_el      = '0;
    burst_el     = '0;
    in_burst     = 1'b0;
    burst_cnt    = '0;
    led_lvl      = '0;
    for (int i = 0; i < LED_COUNT; i++) begin
      led_mode[i] = MODE_HOLD;
    end
  endfunction

  // Computes the LED levels and the accept flag that follow one input word.
  function automatic void blink_step(input lbp_action_t act, input logic [1:0] idx,
                                     input logic [2:0] mode, output led_result_t res);
    logic short_hit, long_hit, burst_hit;
    res.accepted = 1'b1;
    if (act == ACT_TICK) begin
      // Shared timers advance first.
      short_el  = sat_inc(short_el);
      short_hit = (short_el >= short_period);
      if (short_hit) begin
        short_el = '0;
      end
      long_el  = sat_inc(long_el);
      long_hit = (long_el >= long_period);
      if (long_hit) begin
        long_el = '0;
      end
      burst_hit = 1'b0;
      burst_el  = sat_inc(burst_el);
      if (in_burst) begin
        if (burst_el >= short_period) begin
          burst_el  = '0;
          burst_hit = 1'b1;
          if (burst_cnt > burst_limit) begin
            in_burst  = 1'b0;
            burst_cnt = '0;
          end else if (burst_cnt != COUNT_MAX) begin
            burst_cnt = burst_cnt + 1'b1;
          end
        end
      end else if (burst_el >= burst_gap) begin
        burst_el = '0;
        in_burst = 1'b1;
      end
      // Then every LED follows its mode.
      for (int i = 0; i < LED_COUNT; i++) begin
        case (led_mode[i])
          MODE_OFF: begin
            led_lvl[i]  = 1'b0;
            led_mode[i] = MODE_HOLD;
          end
          MODE_ON: begin
            led_lvl[i]  = 1'b1;
            led_mode[i] = MODE_HOLD;
          end
          MODE_SHORT:  if (short_hit) led_lvl[i] = ~led_lvl[i];
          MODE_LONG:   if (long_hit) led_lvl[i] = ~led_lvl[i];
          MODE_TRIPLE: if (burst_hit) led_lvl[i] = ~led_lvl[i];
          default: ;
        endcase
      end
    end else if (mode >= MODE_OFF && mode <= MODE_TRIPLE) begin
      if (idx < LED_COUNT) begin
        led_lvl[idx]  = 1'b0;
        led_mode[idx] = lbp_mode_t'(mode);
      end
    end else begin
      res.accepted = 1'b0;
    end
    res.levels = led_lvl;
  endfunction

  // Offers one word, after a random gap when idle_en is set, and records its expected result on acceptance.
  task automatic send_word(input lbp_action_t act, input logic [1:0] idx,
                           input logic [2:0] mode);
    int unsigned gap;
    led_result_t want;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, mode, idx};
    do @(posedge clk); while (!in_tready);
    blink_step(act, idx, mode, want);
    pending_levels.push_back(want);
  endtask

  // Mostly ticks, a good share of valid commands and some noise.
  task automatic send_random_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      send_word(ACT_TICK, 2'($urandom), 3'($urandom));
    end else if (r < 93) begin
      send_word(ACT_SET, 2'($urandom_range(0, LED_COUNT - 1)),
                3'($urandom_range(MODE_OFF, MODE_TRIPLE)));
    end else begin
      send_word(ACT_SET, 2'($urandom), 3'($urandom));
    end
  endtask

  // Stops offering words and waits until every expected result is back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input lbp_reg_t idx, input logic [TIMER_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SHORT_PERIOD: short_period = value;
      REG_LONG_PERIOD:  long_period  = value;
      REG_BURST_GAP:    burst_gap    = value;
      REG_BURST_LIMIT:  burst_limit  = value[COUNT_W-1:0];
      default: ;
    endcase
  endtask

  // Mostly short periods so that the timers fire often, sometimes the extremes.
  function automatic logic [TIMER_W-1:0] draw_period();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd1;
    if (r == 1) return TIMER_MAX;
    return 16'($urandom_range(1, 7));
  endfunction

  function automatic logic [TIMER_W-1:0] draw_limit();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'd255;
    return 16'($urandom_range(0, 4));
  endfunction

  // Every mode, invalid codes, a missing LED and the field extremes.
  task automatic test_directed_modes();
    send_word(ACT_SET, 2'd0, MODE_ON);
    send_word(ACT_TICK, 2'd3, 3'd7);
    send_word(ACT_SET, 2'd0, MODE_OFF);
    send_word(ACT_TICK, 2'd0, 3'd0);
    send_word(ACT_SET, 2'd1, MODE_ON);
    send_word(ACT_SET, 2'd1, MODE_HOLD);
    send_word(ACT_SET, 2'd2, 3'd6);
    send_word(ACT_SET, 2'd3, 3'd7);
    send_word(ACT_SET, 2'd3, MODE_ON);
    send_word(ACT_TICK, 2'd1, MODE_SHORT);
    wait_drained();
    write_reg(REG_SHORT_PERIOD, 16'd2);
    write_reg(REG_LONG_PERIOD, 16'd3);
    write_reg(REG_BURST_GAP, 16'd2);
    write_reg(REG_BURST_LIMIT, 16'd0);
    send_word(ACT_SET, 2'd0, MODE_SHORT);
    send_word(ACT_SET, 2'd1, MODE_LONG);
    send_word(ACT_SET, 2'd2, MODE_TRIPLE);
    repeat (10) send_word(ACT_TICK, 2'd0, 3'd0);
    // A fresh command pulls the LED low again.
    send_word(ACT_SET, 2'd2, MODE_TRIPLE);
  endtask

  // Zero periods and gap make every comparison true on every tick.
  task automatic test_zero_period();
    wait_drained();
    write_reg(REG_SHORT_PERIOD, 16'd0);
    write_reg(REG_LONG_PERIOD, 16'd0);
    write_reg(REG_BURST_GAP, 16'd0);
    write_reg(REG_BURST_LIMIT, 16'd1);
    send_word(ACT_SET, 2'd0, MODE_SHORT);
    send_word(ACT_SET, 2'd1, MODE_LONG);
    send_word(ACT_SET, 2'd2, MODE_TRIPLE);
    repeat (10) send_word(ACT_TICK, 2'($urandom), 3'($urandom));
  endtask

  // Phases of random words under changing settings; the last one saturates the burst count.
  task automatic test_random_phases();
    for (int p = 0; p < 5; p++) begin
      wait_drained();
      idle_en = (p != 1);
      if (p == 2) begin
        write_reg(REG_SHORT_PERIOD, TIMER_MAX);
        write_reg(REG_LONG_PERIOD, TIMER_MAX);
        write_reg(REG_BURST_GAP, TIMER_MAX);
        write_reg(REG_BURST_LIMIT, 16'd0);
      end else if (p == 4) begin
        write_reg(REG_SHORT_PERIOD, 16'd1);
        write_reg(REG_LONG_PERIOD, 16'd2);
        write_reg(REG_BURST_GAP, 16'd1);
        write_reg(REG_BURST_LIMIT, 16'd255);
      end else begin
        write_reg(REG_SHORT_PERIOD, draw_period());
        write_reg(REG_LONG_PERIOD, draw_period());
        write_reg(REG_BURST_GAP, draw_period());
        write_reg(REG_BURST_LIMIT, draw_limit());
      end
      // Put every LED into a pulse mode first so the toggles show.
      for (int led = 0; led < LED_COUNT; led++) begin
        send_word(ACT_SET, 2'(led), 3'($urandom_range(MODE_SHORT, MODE_TRIPLE)));
      end
      if (p == 4) begin
        repeat (270) send_word(ACT_TICK, 2'($urandom), 3'($urandom));
      end else begin
        repeat (105) send_random_word();
      end
    end
  endtask

  // Long receiver hold-off fills the block, then the sender waits for a full drain.
  task automatic test_backpressure();
    wait_drained();
    write_reg(REG_SHORT_PERIOD, 16'd3);
    write_reg(REG_LONG_PERIOD, 16'd5);
    write_reg(REG_BURST_GAP, 16'd4);
    write_reg(REG_BURST_LIMIT, 16'd2);
    idle_en       = 1'b0;
    hold_off_left = 60;
    repeat (30) send_random_word();
    wait_drained();
    idle_en = 1'b1;
    repeat (20) send_random_word();
  endtask

  // Receiver: random stalls per word plus the long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_tready <= 1'b0;
        hold_off_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compares each result word with the oldest expectation.
  initial begin : result_checker
    led_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_levels.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %h", out_tdata));
        end else begin
          want = pending_levels.pop_front();
          if (out_tdata[2:0] !== want.levels) begin
            report_mismatch($sformatf("led_levels %b, expected %b",
                                      out_tdata[2:0], want.levels));
          end
          if (out_tdata[3] !== want.accepted) begin
            report_mismatch($sformatf("accepted %b, expected %b",
                                      out_tdata[3], want.accepted));
          end
        end
        words_checked++;
        stall_left = idle_en ? $urandom_range(0, 5) : 0;
      end
    end
  end

  // Ends the run when no word moves on either side for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("led_blink_pattern_generator_tb: done, errors");
    $finish;
  end

  // Reset, then the tests in turn.
  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = ACT_TICK;
    cfg_we        = 1'b0;
    cfg_index     = REG_SHORT_PERIOD;
    cfg_wdata     = '0;
    idle_en       = 1'b1;
    stall_left    = 0;
    hold_off_left = 0;
    error_count   = 0;
    words_checked = 0;
    reset_model();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_modes();
    test_zero_period();
    test_random_phases();
    test_backpressure();
    wait_drained();

    if (error_count == 0) begin
      $display("led_blink_pattern_generator_tb: done, clean");
    end else begin
      $display("led_blink_pattern_generator_tb: done, errors");
    end
    $finish;
  end

endmodule
